>>> sv/record_header_crc_checker_top_macros.svh
`ifndef RECORD_HEADER_CRC_CHECKER_TOP_MACROS_SVH
`define RECORD_HEADER_CRC_CHECKER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define RHCC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RHCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rhcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rhcc_pkg;

    localparam int MAX_RECORD_BYTES_DEF = 4096;
    localparam int HEADER_BYTES         = 20;
    localparam int CRC_HEADER_BYTES     = 16;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [7:0]  ERASED_BYTE  = 8'hFF;
    localparam logic [15:0] LEGACY_VERSION     = 16'd1;
    localparam logic [15:0] HEADER_LEN_EXPECT  = 16'd20;

    localparam logic [1:0] ST_VALID       = 2'd0;
    localparam logic [1:0] ST_EMPTY       = 2'd1;
    localparam logic [1:0] ST_CORRUPT     = 2'd2;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

    localparam logic [1:0] REG_CURRENT_VERSION     = 2'd0;
    localparam logic [1:0] REG_LEGACY_PAYLOAD_LEN  = 2'd1;
    localparam logic [1:0] REG_CURRENT_PAYLOAD_LEN = 2'd2;

    localparam logic [15:0] CURRENT_VERSION_RST = 16'd2;

    // record summary after the byte just taken
    typedef struct packed {
        logic        too_short;
        logic        overlong;
        logic        erased;
        logic        magic_ok;
        logic [15:0] header_len;
        logic        payload_too_big;
        logic [15:0] version;
        logic [31:0] payload_len;
        logic [31:0] sequence_num;
        logic        crc_ok;
    } rec_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] val;
        case (pos)
            2'd0:    val = 8'h50;
            2'd1:    val = 8'h43;
            2'd2:    val = 8'h41;
            default: val = 8'h4C;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

>>> sv/record_header_crc_checker_top.sv
// A last byte in stage one loads its result and out_valid once the output stage is free.
// Throughput: one byte per cycle unless stalled; the byte-wide CRC-32 sets the cycle path.
// A result held under out_stall stalls intake only once the next last byte reaches stage one.
// Reset (rst_n low, asynchronous) clears the record state, empties both stages
// and restores the registers: current_version 2, payload lengths 0.
`timescale 1ns / 1ps
`default_nettype none
`include "record_header_crc_checker_top_macros.svh"

module record_header_crc_checker_top #(
    parameter int MAX_RECORD_BYTES = rhcc_pkg::MAX_RECORD_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  record_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      sequence_number,
    output logic [15:0]      record_version
);

    logic [15:0] current_version_reg;
    logic [11:0] legacy_payload_len_reg;
    logic [11:0] current_payload_len_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_fire;
    logic        in_accept;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] sequence_reg;
    logic [15:0] version_reg;
    logic        out_free;
    logic        out_load;

    rhcc_pkg::rec_t rec;
    logic [1:0]     status_next;
    logic [31:0]    sequence_next;
    logic [15:0]    version_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_version_reg     <= rhcc_pkg::CURRENT_VERSION_RST;
            legacy_payload_len_reg  <= '0;
            current_payload_len_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                rhcc_pkg::REG_CURRENT_VERSION:     current_version_reg     <= cfg_data;
                rhcc_pkg::REG_LEGACY_PAYLOAD_LEN:  legacy_payload_len_reg  <= cfg_data[11:0];
                rhcc_pkg::REG_CURRENT_PAYLOAD_LEN: current_payload_len_reg <= cfg_data[11:0];
                default:                           ;
            endcase
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && (!s1_last_reg || out_free);
    assign out_load  = s1_fire && s1_last_reg;
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= record_byte;
            s1_last_reg <= last_byte;
        end
    end

    rhcc_track #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s1_fire),
        .data_byte (s1_byte_reg),
        .last      (s1_last_reg),
        .rec       (rec)
    );

    rhcc_judge u_judge (
        .rec                 (rec),
        .current_version     (current_version_reg),
        .legacy_payload_len  (legacy_payload_len_reg),
        .current_payload_len (current_payload_len_reg),
        .status              (status_next),
        .sequence_number     (sequence_next),
        .record_version      (version_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg   <= status_next;
            sequence_reg <= sequence_next;
            version_reg  <= version_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign sequence_number = sequence_reg;
    assign record_version  = version_reg;

    `RHCC_ASSERT_SAME(a_seq_zero_unless_valid, out_valid && status != rhcc_pkg::ST_VALID, sequence_number == 32'd0, "sequence number set on a non-valid status")
    `RHCC_ASSERT_SAME(a_empty_version_erased, out_valid && status == rhcc_pkg::ST_EMPTY, record_version == 16'hFFFF, "empty status with a non-erased version field")
    `RHCC_ASSERT_NEXT(a_last_gives_result, out_load, out_valid, "last byte processed without a result")
    `RHCC_ASSERT_SAME(a_stall_only_when_held, in_stall, s1_valid_reg && !s1_fire, "input stalled with a free stage")

endmodule

`default_nettype wire

>>> sv/rhcc_track.sv
`timescale 1ns / 1ps
`default_nettype none

module rhcc_track #(
    parameter int MAX_RECORD_BYTES = rhcc_pkg::MAX_RECORD_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last,
    output rhcc_pkg::rec_t   rec
);

    localparam int CNT_W = $clog2(MAX_RECORD_BYTES + 1);

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (rhcc_pkg::CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic             all_erased_reg, all_erased_next;
    logic             magic_match_reg, magic_match_next;
    logic [15:0]      version_reg, version_next;
    logic [15:0]      header_len_reg, header_len_next;
    logic [31:0]      payload_len_reg, payload_len_next;
    logic [31:0]      sequence_reg, sequence_next;
    logic [31:0]      stored_crc_reg, stored_crc_next;
    logic [31:0]      crc_reg, crc_next;
    logic             overlong_reg, overlong_next;

    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] payload_idx;
    logic [CNT_W-1:0] body_bytes;

    assign idx         = byte_count_reg;
    assign payload_idx = idx - CNT_W'(rhcc_pkg::HEADER_BYTES);
    assign body_bytes  = byte_count_next - CNT_W'(rhcc_pkg::HEADER_BYTES);

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        all_erased_next  = all_erased_reg;
        magic_match_next = magic_match_reg;
        version_next     = version_reg;
        header_len_next  = header_len_reg;
        payload_len_next = payload_len_reg;
        sequence_next    = sequence_reg;
        stored_crc_next  = stored_crc_reg;
        crc_next         = crc_reg;
        overlong_next    = overlong_reg;

        if (byte_count_reg == CNT_W'(MAX_RECORD_BYTES))
        begin
            overlong_next = 1'b1;
        end
        else
        begin
            byte_count_next = byte_count_reg + CNT_W'(1);
            if (data_byte != rhcc_pkg::ERASED_BYTE)
            begin
                all_erased_next = 1'b0;
            end
            if (idx < CNT_W'(4))
            begin
                if (data_byte != rhcc_pkg::magic_byte(idx[1:0]))
                begin
                    magic_match_next = 1'b0;
                end
            end
            else if (idx < CNT_W'(6))
            begin
                version_next[{idx[0], 3'b000} +: 8] = data_byte;
            end
            else if (idx < CNT_W'(8))
            begin
                header_len_next[{idx[0], 3'b000} +: 8] = data_byte;
            end
            else if (idx < CNT_W'(12))
            begin
                payload_len_next[{idx[1:0], 3'b000} +: 8] = data_byte;
            end
            else if (idx < CNT_W'(16))
            begin
                sequence_next[{idx[1:0], 3'b000} +: 8] = data_byte;
            end
            else if (idx < CNT_W'(rhcc_pkg::HEADER_BYTES))
            begin
                stored_crc_next[{idx[1:0], 3'b000} +: 8] = data_byte;
            end

            if (idx < CNT_W'(rhcc_pkg::CRC_HEADER_BYTES) ||
                (idx >= CNT_W'(rhcc_pkg::HEADER_BYTES) &&
                 {{(32-CNT_W){1'b0}}, payload_idx} < payload_len_reg))
            begin
                crc_next = crc_byte(crc_reg, data_byte);
            end
        end
    end

    always_comb
    begin
        rec.too_short       = byte_count_next < CNT_W'(rhcc_pkg::HEADER_BYTES);
        rec.overlong        = overlong_next;
        rec.erased          = all_erased_next;
        rec.magic_ok        = magic_match_next;
        rec.header_len      = header_len_next;
        rec.payload_too_big = payload_len_next > {{(32-CNT_W){1'b0}}, body_bytes};
        rec.version         = version_next;
        rec.payload_len     = payload_len_next;
        rec.sequence_num    = sequence_next;
        rec.crc_ok          = (~crc_next) == stored_crc_next;
    end

    // clear on the last byte, advance otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            all_erased_reg  <= 1'b1;
            magic_match_reg <= 1'b1;
            version_reg     <= '0;
            header_len_reg  <= '0;
            payload_len_reg <= '0;
            sequence_reg    <= '0;
            stored_crc_reg  <= '0;
            crc_reg         <= rhcc_pkg::CRC_INIT;
            overlong_reg    <= 1'b0;
        end
        else if (fire)
        begin
            if (last)
            begin
                byte_count_reg  <= '0;
                all_erased_reg  <= 1'b1;
                magic_match_reg <= 1'b1;
                version_reg     <= '0;
                header_len_reg  <= '0;
                payload_len_reg <= '0;
                sequence_reg    <= '0;
                stored_crc_reg  <= '0;
                crc_reg         <= rhcc_pkg::CRC_INIT;
                overlong_reg    <= 1'b0;
            end
            else
            begin
                byte_count_reg  <= byte_count_next;
                all_erased_reg  <= all_erased_next;
                magic_match_reg <= magic_match_next;
                version_reg     <= version_next;
                header_len_reg  <= header_len_next;
                payload_len_reg <= payload_len_next;
                sequence_reg    <= sequence_next;
                stored_crc_reg  <= stored_crc_next;
                crc_reg         <= crc_next;
                overlong_reg    <= overlong_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/rhcc_judge.sv
`timescale 1ns / 1ps
`default_nettype none

module rhcc_judge (
    input  wire rhcc_pkg::rec_t rec,
    input  wire logic [15:0]  current_version,
    input  wire logic [11:0]  legacy_payload_len,
    input  wire logic [11:0]  current_payload_len,
    output logic [1:0]        status,
    output logic [31:0]       sequence_number,
    output logic [15:0]       record_version
);

    logic        is_legacy;
    logic [11:0] want_len;

    assign is_legacy = rec.version == rhcc_pkg::LEGACY_VERSION;
    assign want_len  = is_legacy ? legacy_payload_len : current_payload_len;

    always_comb
    begin
        if (rec.too_short || rec.overlong)
        begin
            status = rhcc_pkg::ST_CORRUPT;
        end
        else if (rec.erased)
        begin
            status = rhcc_pkg::ST_EMPTY;
        end
        else if (!rec.magic_ok || rec.header_len != rhcc_pkg::HEADER_LEN_EXPECT ||
                 rec.payload_too_big)
        begin
            status = rhcc_pkg::ST_CORRUPT;
        end
        else if (!is_legacy && rec.version != current_version)
        begin
            status = rhcc_pkg::ST_UNSUPPORTED;
        end
        else if (!rec.crc_ok || rec.payload_len != {20'd0, want_len})
        begin
            status = rhcc_pkg::ST_CORRUPT;
        end
        else
        begin
            status = rhcc_pkg::ST_VALID;
        end
    end

    assign sequence_number = (status == rhcc_pkg::ST_VALID) ? rec.sequence_num : 32'd0;
    assign record_version  = rec.too_short ? 16'd0 : rec.version;

endmodule

`default_nettype wire
